// ----- design/nsv_pkg.sv -----
package nsv_pkg;

	// Geometry of the column end-row table
	localparam int MAX_COLUMNS = 16;
	localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int COL_LIM_W   = 8;

	// Field widths
	localparam int ROW_W    = 32;
	localparam int COL_W    = 7;
	localparam int PLAYER_W = 4;
	localparam int TYPE_W   = 4;
	localparam int QUANT_W  = 8;
	localparam int CNT_W    = 32;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int PCOL_W   = 8;

	// Stream packing
	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 120;
	localparam int M_USER_W = 4;

	localparam logic [QUANT_W-1:0]   QUANT_MAX       = 8'd192;
	localparam logic [CFG_W-1:0]     CFG_COLS_RST    = 5'd4;
	localparam logic [CFG_W-1:0]     CFG_PLAYERS_RST = 5'd1;
	localparam logic [PCOL_W-1:0]    PREV_COL_RST    = 8'hFF;
	localparam logic [COL_LIM_W-1:0] COL_LIM_MAX     = COL_LIM_W'(MAX_COLUMNS);

	// Queue between classifier and checker
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [2:0] {
		R_KEPT       = 3'd0,
		R_BAD_COL    = 3'd1,
		R_BAD_PLAYER = 3'd2,
		R_OVERLAP    = 3'd3,
		R_UNSORTED   = 3'd4,
		R_BAD_QUANT  = 3'd5,
		R_BAD_CFG    = 3'd6
	} reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_COLS    = 1'b0,
		CFG_NUM_PLAYERS = 1'b1
	} cfg_idx_t;

	// Classified note as it travels through the queue
	typedef struct packed {
		reason_t                   pre_reason;
		logic                      quant_bad;
		logic signed [ROW_W-1:0]   row;
		logic signed [ROW_W-1:0]   end_row;
		logic [COL_W-1:0]          col;
		logic [PLAYER_W-1:0]       player;
		logic [TYPE_W-1:0]         ntype;
		logic [QUANT_W-1:0]        quant;
		logic                      last;
	} item_t;

endpackage

// ----- design/nsv_front.sv -----
module nsv_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nsv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nsv_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nsv_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                            s_tlast,
	input  logic                            q_full,
	output logic                            q_push,
	output nsv_pkg::item_t                  q_item
);

	logic [nsv_pkg::CFG_W-1:0]     num_cols_q;
	logic [nsv_pkg::CFG_W-1:0]     num_players_q;
	logic [nsv_pkg::COL_LIM_W-1:0] col_limit;
	logic [nsv_pkg::COL_LIM_W-1:0] num_cols_ext;
	logic [nsv_pkg::COL_W-1:0]     col;
	logic [nsv_pkg::PLAYER_W-1:0]  player;
	logic [nsv_pkg::QUANT_W-1:0]   quant;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q    <= nsv_pkg::CFG_COLS_RST;
			num_players_q <= nsv_pkg::CFG_PLAYERS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nsv_pkg::CFG_NUM_COLS:    num_cols_q    <= cfg_wdata;
				nsv_pkg::CFG_NUM_PLAYERS: num_players_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign col    = s_tdata[70:64];
	assign player = s_tdata[74:71];
	assign quant  = s_tdata[86:79];

	// Columns above the table size do not exist
	assign num_cols_ext = nsv_pkg::COL_LIM_W'(num_cols_q);
	assign col_limit    = (num_cols_ext > nsv_pkg::COL_LIM_MAX) ? nsv_pkg::COL_LIM_MAX
	                                                            : num_cols_ext;

	always_comb begin
		q_item.row       = s_tdata[31:0];
		q_item.end_row   = s_tdata[63:32];
		q_item.col       = col;
		q_item.player    = player;
		q_item.ntype     = s_tdata[78:75];
		q_item.quant     = quant;
		q_item.last      = s_tlast;
		q_item.quant_bad = (quant == '0) || (quant > nsv_pkg::QUANT_MAX);
		if (num_cols_q == '0 || num_players_q == '0) begin
			q_item.pre_reason = nsv_pkg::R_BAD_CFG;
		end else if (nsv_pkg::COL_LIM_W'(col) >= col_limit) begin
			q_item.pre_reason = nsv_pkg::R_BAD_COL;
		end else if (nsv_pkg::CFG_W'(player) >= num_players_q) begin
			q_item.pre_reason = nsv_pkg::R_BAD_PLAYER;
		end else begin
			q_item.pre_reason = nsv_pkg::R_KEPT;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

// ----- design/nsv_fifo.sv -----
module nsv_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nsv_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output nsv_pkg::item_t head
);

	nsv_pkg::item_t              mem_q [nsv_pkg::QDEPTH];
	logic [nsv_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [nsv_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [nsv_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (count_q == nsv_pkg::QCNT_W'(nsv_pkg::QDEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/nsv_back.sv -----
module nsv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  nsv_pkg::item_t                 q_head,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [nsv_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [nsv_pkg::M_USER_W-1:0]   m_tuser,
	output logic                           m_tlast
);

	logic signed [nsv_pkg::ROW_W-1:0] col_end_q [nsv_pkg::MAX_COLUMNS];
	logic signed [nsv_pkg::ROW_W-1:0] prev_row_q;
	logic [nsv_pkg::PCOL_W-1:0]       prev_col_q;
	logic [nsv_pkg::CNT_W-1:0]        removed_q;

	logic                             m_valid_q;
	nsv_pkg::item_t                   out_item_q;
	nsv_pkg::reason_t                 out_reason_q;
	logic [nsv_pkg::CNT_W-1:0]        out_removed_q;

	logic [nsv_pkg::COL_IDX_W-1:0]    col_idx;
	logic signed [nsv_pkg::ROW_W-1:0] end_rd;
	logic                             overlap;
	logic                             unsorted;
	nsv_pkg::reason_t                 reason;
	logic [nsv_pkg::CNT_W-1:0]        removed_next;

	assign q_pop   = q_valid && (!m_valid_q || m_tready);
	assign col_idx = q_head.col[nsv_pkg::COL_IDX_W-1:0];
	assign end_rd  = col_end_q[col_idx];

	assign overlap  = !(end_rd < q_head.row);
	assign unsorted = (q_head.row < prev_row_q) ||
	                  ((q_head.row == prev_row_q) &&
	                   (nsv_pkg::PCOL_W'(q_head.col) <= prev_col_q));

	always_comb begin
		if (q_head.pre_reason != nsv_pkg::R_KEPT) begin
			reason = q_head.pre_reason;
		end else if (overlap) begin
			reason = nsv_pkg::R_OVERLAP;
		end else if (unsorted) begin
			reason = nsv_pkg::R_UNSORTED;
		end else if (q_head.quant_bad) begin
			reason = nsv_pkg::R_BAD_QUANT;
		end else begin
			reason = nsv_pkg::R_KEPT;
		end
		removed_next = removed_q;
		if (reason != nsv_pkg::R_KEPT && removed_q != '1) begin
			removed_next = removed_q + 1'b1;
		end
	end

	// Chart state: cleared after the last note of a chart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < nsv_pkg::MAX_COLUMNS; i++) begin
				col_end_q[i] <= '1;
			end
			prev_row_q <= '1;
			prev_col_q <= nsv_pkg::PREV_COL_RST;
			removed_q  <= '0;
		end else if (q_pop) begin
			if (q_head.last) begin
				for (int i = 0; i < nsv_pkg::MAX_COLUMNS; i++) begin
					col_end_q[i] <= '1;
				end
				prev_row_q <= '1;
				prev_col_q <= nsv_pkg::PREV_COL_RST;
				removed_q  <= '0;
			end else begin
				removed_q <= removed_next;
				if (reason == nsv_pkg::R_KEPT) begin
					prev_row_q         <= q_head.row;
					prev_col_q         <= nsv_pkg::PCOL_W'(q_head.col);
					col_end_q[col_idx] <= q_head.end_row;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (q_pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_item_q    <= q_head;
			out_reason_q  <= reason;
			out_removed_q <= removed_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = out_item_q.last;
	assign m_tuser  = {out_reason_q, (out_reason_q == nsv_pkg::R_KEPT)};
	assign m_tdata  = {1'b0, out_removed_q, out_item_q.quant, out_item_q.ntype,
	                   out_item_q.player, out_item_q.col, out_item_q.end_row,
	                   out_item_q.row};

`ifndef SYNTH
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.last) |=> (removed_q == '0 && prev_col_q == nsv_pkg::PREV_COL_RST))
		else $error("chart state not cleared after last note");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_head.last) |=> (removed_q >= $past(removed_q)))
		else $error("removed count went backwards within a chart");

	a_kept_moves_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_head.last && reason == nsv_pkg::R_KEPT) |=>
		(prev_row_q == $past(q_head.row)))
		else $error("kept note did not become the sort reference");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_valid_q)
		else $error("popped note not presented");
`endif

endmodule

// ----- design/note_stream_validator.sv -----
// Note stream validator.
// Input stream (s_*): one chart note per transfer; s_tlast marks the final note
// of a chart. Output stream (m_*): exactly one result per note, in order,
// carrying the note back with a keep flag, a reason code and the running count
// of removed notes (saturating). m_tlast echoes the note's last marker.
// Configuration: cfg_we/cfg_index/cfg_wdata write num_cols (index 0) and
// num_players (index 1); write only while no note is in flight.
// Structure: a classifier applies the stateless checks (configuration, column,
// player, quantization) and pushes into a two-entry queue; the checker pops,
// applies the overlap and sort checks against the per-column end-row table and
// the last kept note, then loads the output register.
// Path: each note is registered in the queue and then in the output register
// before its result appears on m_*.
// Throughput: one note per cycle while m_tready stays high; the checker
// does one table read, compare and update per note.
// Reset: arst_n clears the queue, output valid flag and chart state and loads
// num_cols = 4, num_players = 1. Chart state also clears after each last note.
// Back-pressure: while m_tready is low the output holds; the queue absorbs two
// more notes before s_tready drops.
module note_stream_validator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nsv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nsv_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] note_row, [63:32] note_end_row, [70:64] note_col,
	// [74:71] note_player, [78:75] note_type, [86:79] note_quant, [87] zero
	input  logic [nsv_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] out_row, [63:32] out_end_row, [70:64] out_col, [74:71] out_player,
	// [78:75] out_type, [86:79] out_quant, [118:87] removed_total, [119] zero
	output logic [nsv_pkg::M_DATA_W-1:0]   m_tdata,
	// [0] keep, [3:1] reason
	output logic [nsv_pkg::M_USER_W-1:0]   m_tuser,
	output logic                           m_tlast
);

	nsv_pkg::item_t push_item;
	nsv_pkg::item_t head_item;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;

	// Classifier: register file and stateless checks
	nsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// Decoupling queue
	nsv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head_item)
	);

	// Checker: chart state, final reason, output register
	nsv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
